// ===== rtl/core/rfe_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfe_pkg
// Shared sizes, codes and word types for the row filter expression engine.
// ---------------------------------------------------------------------------
package rfe_pkg;

   localparam int MAX_INSTRUCTIONS = 16;
   localparam int NUM_CONSTANTS    = 8;
   localparam int NUM_TEMPORARIES  = 8;
   localparam int NUM_COLUMNS      = 8;
   localparam int VALUE_WIDTH      = 64;

   localparam int PROG_AW   = (MAX_INSTRUCTIONS > 1) ? $clog2(MAX_INSTRUCTIONS) : 1;
   localparam int PC_W      = $clog2(MAX_INSTRUCTIONS + 1);
   localparam int CONST_AW  = (NUM_CONSTANTS > 1) ? $clog2(NUM_CONSTANTS) : 1;
   localparam int COLUMN_AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int TEMP_AW   = (NUM_TEMPORARIES > 1) ? $clog2(NUM_TEMPORARIES) : 1;

   // multiplier operand halves
   localparam int LO_W = VALUE_WIDTH / 2;
   localparam int HI_W = VALUE_WIDTH - LO_W;

   localparam int IDX_W       = 3;
   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_INSTRUCTION_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERDICT_SLOT      = 4'd1;

   localparam logic [1:0] OP_LOAD_CONST = 2'd0;
   localparam logic [1:0] OP_LOAD_INSTR = 2'd1;
   localparam logic [1:0] OP_COLUMN     = 2'd2;
   localparam logic [1:0] OP_CLEAR      = 2'd3;

   localparam logic [1:0] KIND_CONST   = 2'd0;
   localparam logic [1:0] KIND_COLUMN  = 2'd1;
   localparam logic [1:0] KIND_TEMP    = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   localparam logic [3:0] OPC_AND = 4'd0;
   localparam logic [3:0] OPC_OR  = 4'd1;
   localparam logic [3:0] OPC_NOT = 4'd2;
   localparam logic [3:0] OPC_GT  = 4'd3;
   localparam logic [3:0] OPC_LT  = 4'd4;
   localparam logic [3:0] OPC_GE  = 4'd5;
   localparam logic [3:0] OPC_LE  = 4'd6;
   localparam logic [3:0] OPC_EQ  = 4'd7;
   localparam logic [3:0] OPC_NEQ = 4'd8;
   localparam logic [3:0] OPC_ADD = 4'd9;
   localparam logic [3:0] OPC_SUB = 4'd10;
   localparam logic [3:0] OPC_MUL = 4'd11;

   // partial product formed in each multiply step
   localparam logic [1:0] MUL_STEP_LL   = 2'd0;
   localparam logic [1:0] MUL_STEP_LH   = 2'd1;
   localparam logic [1:0] MUL_STEP_HL   = 2'd2;
   localparam logic [1:0] MUL_STEP_DONE = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [3:0]        slot;
      logic signed [63:0] value;
      logic [3:0]        opcode;
      logic [1:0]        left_kind;
      logic [2:0]        left_index;
      logic [1:0]        right_kind;
      logic [2:0]        right_index;
      logic [1:0]        dest_kind;
      logic [2:0]        dest_index;
      logic              last_column;
   } rfe_req_type;

   typedef struct packed {
      logic row_pass;
      logic fault;
   } rfe_rsp_type;

   typedef struct packed {
      logic [3:0]       opcode;
      logic [1:0]       lk;
      logic [IDX_W-1:0] li;
      logic [1:0]       rk;
      logic [IDX_W-1:0] ri;
      logic [1:0]       dk;
      logic [IDX_W-1:0] di;
   } rfe_instr_type;

   localparam int INSTR_W = $bits(rfe_instr_type);

   typedef struct packed {
      logic               accept;
      logic               start;
      logic               load_left;
      logic               load_right;
      logic               execute;
      logic               mul_run;
      logic [1:0]         mul_step;
      logic               post;
      logic [PROG_AW-1:0] prog_addr;
   } rfe_cmd_type;

   typedef struct packed {
      logic row_end;
      logic is_mul;
   } rfe_status_type;

endpackage

// ===== rtl/core/rfe_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfe_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module rfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rfe_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfe_datapath
// Register files, program store, ALU and stepped multiplier.
// ---------------------------------------------------------------------------
module rfe_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  rfe_pkg::rfe_req_type               req_word,
   input  logic                               csr_write,
   input  logic [rfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rfe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  rfe_pkg::rfe_cmd_type               cmd,
   output rfe_pkg::rfe_status_type            status,
   output rfe_pkg::rfe_rsp_type               rsp_word
);
   import rfe_pkg::*;

   logic [VALUE_WIDTH-1:0] const_ff  [NUM_CONSTANTS];
   logic [VALUE_WIDTH-1:0] column_ff [NUM_COLUMNS];
   logic [VALUE_WIDTH-1:0] temp_ff   [NUM_TEMPORARIES];
   logic [IDX_W-1:0]       verdict_ff;
   logic                   fault_ff;

   rfe_instr_type          instr_ff;
   logic [VALUE_WIDTH-1:0] left_ff;
   logic [VALUE_WIDTH-1:0] right_ff;
   logic [VALUE_WIDTH-1:0] acc_ff;
   logic [2*HI_W-1:0]      prod_ff;
   logic [2*HI_W-1:0]      prod_in;
   rfe_rsp_type            rsp_ff;

   rfe_instr_type          new_instr;
   rfe_instr_type          prog_rd;
   logic [INSTR_W-1:0]     prog_rd_bits;
   logic                   prog_wr_en;

   logic [VALUE_WIDTH-1:0] in_value;
   logic [1:0]             rd_kind;
   logic [IDX_W-1:0]       rd_idx;
   logic [VALUE_WIDTH-1:0] operand;
   logic [VALUE_WIDTH-1:0] alu_res;
   logic                   alu_bad;
   logic                   kind_bad;
   logic                   is_mul;
   logic [HI_W-1:0]        mul_a;
   logic [HI_W-1:0]        mul_b;
   logic [VALUE_WIDTH-1:0] mul_term;
   logic                   wr_en;
   logic [VALUE_WIDTH-1:0] wr_value;

   assign in_value = req_word.value[VALUE_WIDTH-1:0];

   // program store
   always_comb begin
      new_instr.opcode = req_word.opcode;
      new_instr.lk     = req_word.left_kind;
      new_instr.li     = req_word.left_index;
      new_instr.rk     = req_word.right_kind;
      new_instr.ri     = req_word.right_index;
      new_instr.dk     = req_word.dest_kind;
      new_instr.di     = req_word.dest_index;
   end

   assign prog_wr_en = cmd.accept && (req_word.operation == OP_LOAD_INSTR)
                       && (int'(req_word.slot) < MAX_INSTRUCTIONS);

   rfe_ram #(
      .WIDTH (INSTR_W),
      .DEPTH (MAX_INSTRUCTIONS)
   ) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_wr_en),
      .wr_addr (PROG_AW'(req_word.slot)),
      .wr_data (new_instr),
      .rd_addr (cmd.prog_addr),
      .rd_data (prog_rd_bits)
   );

   assign prog_rd = prog_rd_bits;

   // single operand read port: left, right or verdict
   always_comb begin
      rd_kind = instr_ff.rk;
      rd_idx  = instr_ff.ri;
      if (cmd.load_left) begin
         rd_kind = prog_rd.lk;
         rd_idx  = prog_rd.li;
      end else if (cmd.post) begin
         rd_kind = KIND_TEMP;
         rd_idx  = verdict_ff;
      end
      operand = '0;
      case (rd_kind)
         KIND_CONST: begin
            if (int'(rd_idx) < NUM_CONSTANTS) operand = const_ff[CONST_AW'(rd_idx)];
         end
         KIND_COLUMN: begin
            if (int'(rd_idx) < NUM_COLUMNS) operand = column_ff[COLUMN_AW'(rd_idx)];
         end
         KIND_TEMP: begin
            if (int'(rd_idx) < NUM_TEMPORARIES) operand = temp_ff[TEMP_AW'(rd_idx)];
         end
         default: operand = '0;
      endcase
   end

   always_comb begin
      alu_res = '0;
      alu_bad = 1'b0;
      case (instr_ff.opcode)
         OPC_AND: alu_res = left_ff & right_ff;
         OPC_OR:  alu_res = left_ff | right_ff;
         OPC_NOT: alu_res[0] = ~left_ff[0];
         OPC_GT:  alu_res[0] = $signed(left_ff) > $signed(right_ff);
         OPC_LT:  alu_res[0] = $signed(left_ff) < $signed(right_ff);
         OPC_GE:  alu_res[0] = $signed(left_ff) >= $signed(right_ff);
         OPC_LE:  alu_res[0] = $signed(left_ff) <= $signed(right_ff);
         OPC_EQ:  alu_res[0] = left_ff == right_ff;
         OPC_NEQ: alu_res[0] = left_ff != right_ff;
         OPC_ADD: alu_res = left_ff + right_ff;
         OPC_SUB: alu_res = left_ff - right_ff;
         OPC_MUL: alu_res = '0;
         default: alu_bad = 1'b1;
      endcase
   end

   assign kind_bad = (instr_ff.lk == KIND_INVALID) || (instr_ff.rk == KIND_INVALID)
                     || (instr_ff.dk == KIND_INVALID);
   assign is_mul   = instr_ff.opcode == OPC_MUL;

   // a*b mod 2^W = lo*lo + ((lo*hi + hi*lo) << LO_W)
   always_comb begin
      case (cmd.mul_step)
         MUL_STEP_LL: begin
            mul_a = HI_W'(left_ff[LO_W-1:0]);
            mul_b = HI_W'(right_ff[LO_W-1:0]);
         end
         MUL_STEP_LH: begin
            mul_a = HI_W'(left_ff[LO_W-1:0]);
            mul_b = right_ff[VALUE_WIDTH-1:LO_W];
         end
         MUL_STEP_HL: begin
            mul_a = left_ff[VALUE_WIDTH-1:LO_W];
            mul_b = HI_W'(right_ff[LO_W-1:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign mul_term = VALUE_WIDTH'(prod_ff) << LO_W;

   assign wr_en    = (cmd.execute && !is_mul) || (cmd.mul_run && (cmd.mul_step == MUL_STEP_DONE));
   assign wr_value = is_mul ? (acc_ff + mul_term) : alu_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CONSTANTS; i++) const_ff[i] <= '0;
         for (int i = 0; i < NUM_COLUMNS; i++) column_ff[i] <= '0;
         for (int i = 0; i < NUM_TEMPORARIES; i++) temp_ff[i] <= '0;
         verdict_ff <= '0;
         fault_ff   <= 1'b0;
      end else begin
         if (csr_write && (csr_index == CSR_VERDICT_SLOT)) begin
            verdict_ff <= csr_wdata[IDX_W-1:0];
         end
         if (cmd.accept) begin
            case (req_word.operation)
               OP_LOAD_CONST: begin
                  if (int'(req_word.slot) < NUM_CONSTANTS) begin
                     const_ff[CONST_AW'(req_word.slot)] <= in_value;
                  end
               end
               OP_COLUMN: begin
                  if (int'(req_word.slot) < NUM_COLUMNS) begin
                     column_ff[COLUMN_AW'(req_word.slot)] <= in_value;
                  end
               end
               OP_CLEAR: begin
                  for (int i = 0; i < NUM_TEMPORARIES; i++) temp_ff[i] <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.start) begin
            fault_ff <= 1'b0;
         end else if (cmd.execute) begin
            fault_ff <= fault_ff | alu_bad | kind_bad;
         end
         if (wr_en) begin
            case (instr_ff.dk)
               KIND_CONST: begin
                  if (int'(instr_ff.di) < NUM_CONSTANTS) const_ff[CONST_AW'(instr_ff.di)] <= wr_value;
               end
               KIND_COLUMN: begin
                  if (int'(instr_ff.di) < NUM_COLUMNS) column_ff[COLUMN_AW'(instr_ff.di)] <= wr_value;
               end
               KIND_TEMP: begin
                  if (int'(instr_ff.di) < NUM_TEMPORARIES) temp_ff[TEMP_AW'(instr_ff.di)] <= wr_value;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_left) begin
         instr_ff <= prog_rd;
         left_ff  <= operand;
      end
      if (cmd.load_right) begin
         right_ff <= operand;
      end
      prod_ff <= prod_in;
      if (cmd.mul_run) begin
         case (cmd.mul_step)
            MUL_STEP_LH: acc_ff <= VALUE_WIDTH'(prod_ff);
            MUL_STEP_HL: acc_ff <= acc_ff + mul_term;
            default: ;
         endcase
      end
      if (cmd.post) begin
         rsp_ff.row_pass <= operand != '0;
         rsp_ff.fault    <= fault_ff;
      end
   end

   assign status.row_end = (req_word.operation == OP_COLUMN) && req_word.last_column;
   assign status.is_mul  = is_mul;
   assign rsp_word       = rsp_ff;

endmodule

// ===== rtl/core/rfe_controller.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfe_controller
// Sequencer: word intake, per-instruction steps, verdict hand-off.
// ---------------------------------------------------------------------------
module rfe_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            csr_write,
   input  logic [rfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rfe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  rfe_pkg::rfe_status_type         status,
   output rfe_pkg::rfe_cmd_type            cmd
);
   import rfe_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_FETCH   = 4'd1;
   localparam logic [3:0] S_LEFT    = 4'd2;
   localparam logic [3:0] S_RIGHT   = 4'd3;
   localparam logic [3:0] S_EXEC    = 4'd4;
   localparam logic [3:0] S_MUL1    = 4'd5;
   localparam logic [3:0] S_MUL2    = 4'd6;
   localparam logic [3:0] S_MUL3    = 4'd7;
   localparam logic [3:0] S_VERDICT = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [PC_W-1:0]    count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] count_wr;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.prog_addr = PROG_AW'(pc_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.row_end) begin
                  cmd.start = 1'b1;
                  pc_in     = '0;
                  state_in  = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            state_in = (pc_ff == count_ff) ? S_VERDICT : S_LEFT;
         end
         S_LEFT: begin
            cmd.load_left = 1'b1;
            state_in      = S_RIGHT;
         end
         S_RIGHT: begin
            cmd.load_right = 1'b1;
            state_in       = S_EXEC;
         end
         S_EXEC: begin
            cmd.execute  = 1'b1;
            cmd.mul_step = MUL_STEP_LL;
            if (status.is_mul) begin
               state_in = S_MUL1;
            end else begin
               pc_in    = pc_ff + PC_W'(1);
               state_in = S_FETCH;
            end
         end
         S_MUL1: begin
            cmd.mul_run  = 1'b1;
            cmd.mul_step = MUL_STEP_LH;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_run  = 1'b1;
            cmd.mul_step = MUL_STEP_HL;
            state_in     = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul_run  = 1'b1;
            cmd.mul_step = MUL_STEP_DONE;
            pc_in        = pc_ff + PC_W'(1);
            state_in     = S_FETCH;
         end
         S_VERDICT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.post     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign count_wr = csr_wdata[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_index == CSR_INSTRUCTION_COUNT)) begin
            count_ff <= (int'(count_wr) > MAX_INSTRUCTIONS) ? PC_W'(MAX_INSTRUCTIONS)
                                                            : PC_W'(count_wr);
         end
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/row_filter_expression_engine_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// row_filter_expression_engine_top
// Row filter engine: runs a small loaded program over each row's columns.
// ---------------------------------------------------------------------------
// Request words load constants, program entries or column values, or clear
// the temporaries; each is taken in one cycle. A column word flagged as the
// last of its row starts the program: req_ready then drops until the
// verdict word is registered on the response side. Every instruction takes
// fetch, left read, right read and execute through one operand read port
// and one ALU; a multiply adds three passes through a half-width
// multiplier. The response register holds the verdict until taken; new
// words are accepted meanwhile, and a following row waits in its final
// step only if the previous verdict is still pending.
// Configuration writes (instruction count, verdict slot) are always ready
// and belong in idle periods. Reset zeroes the constant, column and
// temporary files and both registers; program entries are undefined until
// loaded.
// ---------------------------------------------------------------------------
module row_filter_expression_engine_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rfe_pkg::rfe_req_type            req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rfe_pkg::rfe_rsp_type            rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rfe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rfe_pkg::*;

   rfe_cmd_type    cmd;
   rfe_status_type status;
   logic           csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   rfe_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   rfe_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

   a_row_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.operation == OP_COLUMN) && req_word.last_column
      |=> !req_ready)
      else $error("intake open after last column word");

   a_post_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> (!rsp_valid || rsp_ready))
      else $error("verdict overwrote a pending response");

   a_rsp_after_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised outside an evaluation");

   a_exec_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> !req_ready)
      else $error("intake reopened straight after execute");

endmodule
